// ===== sv/vpi_pkg.sv =====
// shared types and constants for the vector point inhibition unit
`default_nettype none

package vpi_pkg;

    localparam int COORD_W = 12;
    localparam int DIFF_W  = 13;
    localparam int FWD_W   = 25;
    localparam int LAT_W   = 50;
    localparam int MAG_W   = 24;
    localparam int ENTRY_W = 72;

    localparam logic [24:0] FWD_RESET = 25'd65536;
    localparam logic [24:0] BWD_RESET = 25'd6554;
    localparam logic [49:0] LAT_RESET = 50'd171793449;
    localparam logic [23:0] MAG_RESET = 24'd0;

    localparam logic [1:0] REG_FWD = 2'd0;
    localparam logic [1:0] REG_BWD = 2'd1;
    localparam logic [1:0] REG_LAT = 2'd2;
    localparam logic [1:0] REG_MAG = 2'd3;

    typedef enum logic [1:0] {
        VERDICT_STORED  = 2'd0,
        VERDICT_WEAK    = 2'd1,
        VERDICT_INHIBIT = 2'd2,
        VERDICT_FULL    = 2'd3
    } verdict_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAG,
        ST_READ,
        ST_TEST,
        ST_DONE,
        ST_OUT
    } state_t;

    // zone thresholds handed to the compare unit
    typedef struct packed {
        logic [24:0] fwd;
        logic [24:0] bwd;
        logic [49:0] lat;
    } zone_cfg_t;

endpackage

`default_nettype wire

// ===== sv/vpi_cfg.sv =====
// apb register file for the zone and magnitude limits
`default_nettype none

module vpi_cfg (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready,
    output vpi_pkg::zone_cfg_t zone_cfg,
    output logic      [23:0] mag_thr
);

    logic [24:0] fwd_reg;
    logic [24:0] bwd_reg;
    logic [49:0] lat_reg;
    logic [23:0] mag_reg;
    logic        wr_en;
    logic [1:0]  idx;
    logic        in_range;

    assign pready   = 1'b1;
    assign wr_en    = psel & penable & pwrite;
    assign idx      = paddr[4:3];
    assign in_range = (paddr[2:0] == 3'd0);

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= vpi_pkg::FWD_RESET;
            bwd_reg <= vpi_pkg::BWD_RESET;
            lat_reg <= vpi_pkg::LAT_RESET;
            mag_reg <= vpi_pkg::MAG_RESET;
        end
        else if (wr_en && in_range)
        begin
            unique case (idx)
                vpi_pkg::REG_FWD: fwd_reg <= pwdata[24:0];
                vpi_pkg::REG_BWD: bwd_reg <= pwdata[24:0];
                vpi_pkg::REG_LAT: lat_reg <= pwdata[49:0];
                vpi_pkg::REG_MAG: mag_reg <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        prdata = 64'd0;
        if (in_range)
        begin
            unique case (idx)
                vpi_pkg::REG_FWD: prdata = {39'd0, fwd_reg};
                vpi_pkg::REG_BWD: prdata = {39'd0, bwd_reg};
                vpi_pkg::REG_LAT: prdata = {14'd0, lat_reg};
                vpi_pkg::REG_MAG: prdata = {40'd0, mag_reg};
                default: prdata = 64'd0;
            endcase
        end
    end

    assign zone_cfg = '{fwd: fwd_reg, bwd: bwd_reg, lat: lat_reg};
    assign mag_thr  = mag_reg;

endmodule

`default_nettype wire

// ===== sv/vpi_zone.sv =====
// shared zone test unit: one stored point per pass, three register stages
`default_nettype none

module vpi_zone (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic        [71:0] entry,
    input  wire logic        [35:0] pos,
    input  wire vpi_pkg::zone_cfg_t zone_cfg,
    output logic                    hit_valid,
    output logic                    hit
);

    logic signed [12:0] dx, dy, dz;
    logic signed [11:0] vx, vy, vz;
    logic signed [26:0] dot_reg, dot_next;
    logic        [26:0] dd_reg, dd_next;
    logic        [23:0] vv_reg, vv_next;
    logic        [49:0] vvdd_reg;
    logic        [53:0] dot2_reg;
    logic               fb_reg;
    logic               s1_reg, s2_reg;
    logic        [49:0] lat;

    // offset between the new point and the stored one, and its sums of products
    always_comb
    begin
        dx = 13'(signed'(pos[11:0]))  - 13'(signed'(entry[11:0]));
        dy = 13'(signed'(pos[23:12])) - 13'(signed'(entry[23:12]));
        dz = 13'(signed'(pos[35:24])) - 13'(signed'(entry[35:24]));
        vx = signed'(entry[47:36]);
        vy = signed'(entry[59:48]);
        vz = signed'(entry[71:60]);
        dot_next = 27'(dx * vx) + 27'(dy * vy) + 27'(dz * vz);
        dd_next  = 27'(dx * dx) + 27'(dy * dy) + 27'(dz * dz);
        vv_next  = 24'(vx * vx) + 24'(vy * vy) + 24'(vz * vz);
    end

    // stage one: sums of products
    always_ff @(posedge clk)
    begin
        dot_reg <= dot_next;
        dd_reg  <= dd_next;
        vv_reg  <= vv_next;
    end

    // stage two: squares and the reach bounds
    always_ff @(posedge clk)
    begin
        vvdd_reg <= 50'(vv_reg * dd_reg);
        dot2_reg <= 54'(dot_reg * dot_reg);
        fb_reg   <= (dot_reg < signed'({2'd0, zone_cfg.fwd}))
                    && ($signed({{3{1'b0}}, zone_cfg.bwd}) > -28'(dot_reg));
    end

    assign lat = vvdd_reg - dot2_reg[49:0];

    // valid pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg    <= 1'b0;
            s2_reg    <= 1'b0;
            hit_valid <= 1'b0;
        end
        else
        begin
            s1_reg    <= start;
            s2_reg    <= s1_reg;
            hit_valid <= s2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        hit <= fb_reg && (lat < zone_cfg.lat);
    end

endmodule

`default_nettype wire

// ===== sv/vector_point_inhibition_unit.sv =====
// top level of the vector point inhibition unit
//
// s_axis carries one point and its vector per word; m_axis returns one
// verdict word per input word. apb sets the forward, backward and lateral
// reach and the minimum squared vector magnitude.
// Each word with a strong enough vector is tested against the stored
// points in turn, up to the first hit, through one shared zone unit
// (table read plus a three-stage compare). s_axis_tready is high only
// when the unit is idle. The verdict sits in an output register until
// taken; a stalled receiver holds the unit in its output state, nothing
// is lost.
// Reset clears the stored point count; table contents are not cleared
// since only entries below the count are read. A set first flag empties
// the table before the word is judged.
`default_nettype none

module vector_point_inhibition_unit #(
    parameter int TABLE_DEPTH = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // tdata: pos_x, pos_y, pos_z, vec_x, vec_y, vec_z (12 bits each)
    input  wire logic [71:0] s_axis_tdata,
    // tuser: first
    input  wire logic        s_axis_tuser,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: kept, verdict[1:0], stored_count[8:0], zero pad
    output logic      [15:0] m_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    vpi_pkg::state_t    state_reg, state_next;
    vpi_pkg::zone_cfg_t zone_cfg;
    logic [23:0]        mag_thr;
    logic [71:0]        item_reg;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      k_reg, k_next;
    logic [1:0]         verdict_reg, verdict_next;
    logic [23:0]        mag2;
    logic [71:0]        mem [TABLE_DEPTH];
    logic [71:0]        rd_reg;
    logic               zone_start;
    logic               hit_valid, hit;
    logic               out_valid_reg;
    logic [15:0]        out_data_reg;
    logic               mem_we;
    logic               accept;

    vpi_cfg u_cfg (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready), .zone_cfg(zone_cfg), .mag_thr(mag_thr)
    );

    vpi_zone u_zone (
        .clk(clk), .rst_n(rst_n), .start(zone_start), .entry(rd_reg),
        .pos(item_reg[35:0]), .zone_cfg(zone_cfg),
        .hit_valid(hit_valid), .hit(hit)
    );

    assign accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == vpi_pkg::ST_IDLE);

    // squared vector magnitude
    always_comb
    begin
        mag2 = 24'(signed'(item_reg[47:36]) * signed'(item_reg[47:36]))
             + 24'(signed'(item_reg[59:48]) * signed'(item_reg[59:48]))
             + 24'(signed'(item_reg[71:60]) * signed'(item_reg[71:60]));
    end

    // point table, read ahead at the next scan index
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[count_reg[AW-1:0]] <= {item_reg[71:36], item_reg[35:0]};
        rd_reg <= mem[k_next[AW-1:0]];
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= vpi_pkg::ST_IDLE;
            count_reg   <= '0;
            k_reg       <= '0;
            verdict_reg <= vpi_pkg::VERDICT_STORED;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            k_reg       <= k_next;
            verdict_reg <= verdict_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= {s_axis_tdata[71:36], s_axis_tdata[35:0]};
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        k_next       = k_reg;
        verdict_next = verdict_reg;
        zone_start   = 1'b0;
        mem_we       = 1'b0;
        unique case (state_reg)
            vpi_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_axis_tuser)
                        count_next = '0;
                    k_next     = '0;
                    state_next = vpi_pkg::ST_MAG;
                end
            end
            vpi_pkg::ST_MAG:
            begin
                if (mag2 == 24'd0 || mag2 < mag_thr)
                begin
                    verdict_next = vpi_pkg::VERDICT_WEAK;
                    state_next   = vpi_pkg::ST_OUT;
                end
                else
                begin
                    verdict_next = vpi_pkg::VERDICT_STORED;
                    state_next   = (k_reg < count_reg) ? vpi_pkg::ST_READ
                                                       : vpi_pkg::ST_DONE;
                end
            end
            vpi_pkg::ST_READ:
            begin
                zone_start = 1'b1;
                state_next = vpi_pkg::ST_TEST;
            end
            vpi_pkg::ST_TEST:
            begin
                if (hit_valid)
                begin
                    if (hit)
                    begin
                        verdict_next = vpi_pkg::VERDICT_INHIBIT;
                        state_next   = vpi_pkg::ST_OUT;
                    end
                    else if (k_reg + CW'(1) < count_reg)
                    begin
                        k_next     = k_reg + CW'(1);
                        state_next = vpi_pkg::ST_READ;
                    end
                    else
                        state_next = vpi_pkg::ST_DONE;
                end
            end
            vpi_pkg::ST_DONE:
            begin
                if (count_reg < CW'(TABLE_DEPTH))
                begin
                    mem_we       = 1'b1;
                    count_next   = count_reg + CW'(1);
                    verdict_next = vpi_pkg::VERDICT_STORED;
                end
                else
                    verdict_next = vpi_pkg::VERDICT_FULL;
                state_next = vpi_pkg::ST_OUT;
            end
            vpi_pkg::ST_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                    state_next = vpi_pkg::ST_IDLE;
            end
            default: state_next = vpi_pkg::ST_IDLE;
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == vpi_pkg::ST_OUT && (!out_valid_reg || m_axis_tready))
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == vpi_pkg::ST_OUT && (!out_valid_reg || m_axis_tready))
            out_data_reg <= {4'd0, 9'(count_reg), verdict_reg,
                             (verdict_reg == vpi_pkg::VERDICT_STORED
                              || verdict_reg == vpi_pkg::VERDICT_FULL)};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // count never exceeds the table depth
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("stored count beyond table depth");

    // a table write only ever grows the count by one
    a_grow: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> count_reg == $past(count_reg) + CW'(1))
        else $error("table write without count step");

    // the scan index stays below the count while testing
    a_scan: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == vpi_pkg::ST_READ |-> k_reg < count_reg)
        else $error("scan past stored points");

endmodule

`default_nettype wire
